FILE: rtl/core/a32z_pkg.sv
`default_nettype none
package a32z_pkg;

  localparam logic [15:0] ADLER_MOD = 16'd65521;
  localparam logic [15:0] LOW_INIT = 16'd1;
  localparam logic [15:0] HIGH_INIT = 16'd0;

  // 2^16 mod 65521
  localparam logic [3:0] WRAP_FACTOR = 4'd15;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ZRUN = 1'b1;

  // One queued request: a byte in val[7:0], or a run length folded to 20 bits.
  typedef struct packed {
    logic        op;
    logic [19:0] val;
    logic        last;
  } q_entry_t;

  // a + b mod 65521 for a, b below 65521.
  function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = 17'(a) + 17'(b);
    if (s >= 17'(ADLER_MOD)) begin
      s = s - 17'(ADLER_MOD);
    end
    return s[15:0];
  endfunction

  // Fold a 20-bit value once more and finish the reduction mod 65521.
  function automatic logic [15:0] reduce20(input logic [19:0] x);
    logic [16:0] s;
    s = 17'(x[19:16]) * 17'(WRAP_FACTOR) + 17'(x[15:0]);
    if (s >= 17'(ADLER_MOD)) begin
      s = s - 17'(ADLER_MOD);
    end
    return s[15:0];
  endfunction

  // First fold of a 32-bit value: hi*15 + lo, stays below 2^20.
  function automatic logic [19:0] fold32(input logic [31:0] x);
    return 20'(x[31:16]) * 20'(WRAP_FACTOR) + 20'(x[15:0]);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/adler32_with_zero_runs_top.sv
`default_nettype none
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------
// in      | in_valid, in_ready  | operation, data_byte, run_length, last
// out     | out_valid, out_ready| checksum (high sum 31:16, low sum 15:0)
//
// Bytes retire back to back, one per cycle, at the queue head while the back
// end is idle and a last byte finds the output free. A zero-run request holds
// the back end to take it, reduce the length, multiply by the low sum, fold
// twice, accumulate. out_valid rises in the cycle after a last item retires.
// Reset sets the sums to 1 and 0 and empties the queue; no clearing pass.
// The queue takes up to QUEUE_DEPTH requests while a run or a held output
// stalls the back end, then drops in_ready.
module adler32_with_zero_runs_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] run_length,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      checksum
);
  import a32z_pkg::*;

  q_entry_t front_entry;
  q_entry_t head_entry;
  logic     head_valid;
  logic     head_ready;

  // Front: classify each request and pre-fold run lengths.
  a32z_front u_front (
    .operation  (operation),
    .data_byte  (data_byte),
    .run_length (run_length),
    .last       (last),
    .entry      (front_entry)
  );

  // Queue: decouple acceptance from execution.
  a32z_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_entry (front_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_entry  (head_entry)
  );

  // Back: advance the sums and drive the output register.
  a32z_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_ready   (head_ready),
    .q_entry   (head_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .checksum  (checksum)
  );

endmodule
`default_nettype wire

FILE: rtl/core/a32z_front.sv
`default_nettype none
module a32z_front (
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] run_length,
  input  wire logic        last,
  output a32z_pkg::q_entry_t entry
);
  import a32z_pkg::*;

  // Classify the request and pre-fold run lengths toward mod 65521.
  always_comb begin
    entry.op   = operation;
    entry.last = last;
    if (operation == OP_ZRUN) begin
      entry.val = fold32(run_length);
    end else begin
      entry.val = {12'd0, data_byte};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/a32z_fifo.sv
`default_nettype none
module a32z_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire a32z_pkg::q_entry_t push_entry,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output a32z_pkg::q_entry_t      pop_entry
);
  import a32z_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  q_entry_t      slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/a32z_back.sv
`default_nettype none
module a32z_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire a32z_pkg::q_entry_t q_entry,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             checksum
);
  import a32z_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NRED  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_PFOLD = 3'd3;
  localparam logic [2:0] ST_PRED  = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;

  logic [2:0]  state;
  logic [15:0] low_sum;
  logic [15:0] high_sum;
  logic [31:0] work;
  logic        zlast;

  logic        out_free;
  logic [15:0] low_next;
  logic [15:0] high_next;
  logic [15:0] high_acc;
  logic        byte_go;
  logic        zrun_go;
  logic        acc_go;
  logic        emit;

  assign out_free  = !out_valid || out_ready;
  assign low_next  = add_mod(low_sum, {8'd0, q_entry.val[7:0]});
  assign high_next = add_mod(high_sum, low_next);
  assign high_acc  = add_mod(high_sum, work[15:0]);

  assign byte_go = (state == ST_IDLE) && q_valid && (q_entry.op == OP_BYTE)
                   && (!q_entry.last || out_free);
  assign zrun_go = (state == ST_IDLE) && q_valid && (q_entry.op == OP_ZRUN);
  assign acc_go  = (state == ST_ACC) && (!zlast || out_free);
  assign q_ready = byte_go || zrun_go;
  assign emit    = (byte_go && q_entry.last) || (acc_go && zlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      low_sum   <= LOW_INIT;
      high_sum  <= HIGH_INIT;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (byte_go) begin
            if (q_entry.last) begin
              low_sum   <= LOW_INIT;
              high_sum  <= HIGH_INIT;
            end else begin
              low_sum  <= low_next;
              high_sum <= high_next;
            end
          end else if (zrun_go) begin
            state <= ST_NRED;
          end
        end
        ST_NRED:  state <= ST_MUL;
        ST_MUL:   state <= ST_PFOLD;
        ST_PFOLD: state <= ST_PRED;
        ST_PRED:  state <= ST_ACC;
        ST_ACC: begin
          if (acc_go) begin
            state <= ST_IDLE;
            if (zlast) begin
              low_sum   <= LOW_INIT;
              high_sum  <= HIGH_INIT;
            end else begin
              high_sum <= high_acc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath for zero runs and the output register.
  always_ff @(posedge clk) begin
    if (byte_go && q_entry.last) begin
      checksum <= {high_next, low_next};
    end else if (acc_go && zlast) begin
      checksum <= {high_acc, low_sum};
    end
    unique case (state)
      ST_IDLE: begin
        if (zrun_go) begin
          work  <= {12'd0, q_entry.val};
          zlast <= q_entry.last;
        end
      end
      ST_NRED:  work <= {16'd0, reduce20(work[19:0])};
      ST_MUL:   work <= 32'(work[15:0]) * 32'(low_sum);
      ST_PFOLD: work <= {12'd0, fold32(work)};
      ST_PRED:  work <= {16'd0, reduce20(work[19:0])};
      default:  work <= work;
    endcase
  end

endmodule
`default_nettype wire
